/* hw/rtl/pid_controller_position_delta_defines.svh */
// ----------------------------------------------------------------------------
// pid controller assertion macros
// shared property forms for the controller checks
// ----------------------------------------------------------------------------
`ifndef PID_CONTROLLER_POSITION_DELTA_DEFINES_SVH
`define PID_CONTROLLER_POSITION_DELTA_DEFINES_SVH

// same-cycle implication
`define PIDPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIDPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/pidpd_pkg.sv */
// ----------------------------------------------------------------------------
// pid controller package
// register indexes, loop modes and saturation helpers
// ----------------------------------------------------------------------------
package pidpd_pkg;

   typedef enum logic [2:0] {
      REG_LOOP_MODE      = 3'd0,
      REG_KP_GAIN        = 3'd1,
      REG_KI_GAIN        = 3'd2,
      REG_KD_GAIN        = 3'd3,
      REG_OUTPUT_LIMIT   = 3'd4,
      REG_INTEGRAL_LIMIT = 3'd5,
      REG_INTEGRAL_BAND  = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_POSITIONAL  = 2'd0,
      MODE_INCREMENTAL = 2'd1,
      MODE_HOLD        = 2'd2
   } loop_mode_type;

   localparam int CSR_DATA_W = 31;
   localparam logic [30:0] LIMIT_RESET = 31'h7FFF_FFFF;
   localparam logic [16:0] BAND_RESET  = 17'd65536;

   // saturate a product to +/- (2^31 - 1)
   function automatic logic signed [31:0] sat_term(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -43'sd2147483647) begin
         r = 32'sh8000_0001;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // symmetric clamp to an unsigned limit
   function automatic logic signed [31:0] clamp_lim(input logic signed [33:0] v,
                                                   input logic [30:0] lim);
      logic signed [33:0] pos;
      logic signed [33:0] neg;
      logic signed [33:0] r;
      pos = signed'({3'b000, lim});
      neg = -pos;
      if (v > pos) begin
         r = pos;
      end else if (v < neg) begin
         r = neg;
      end else begin
         r = v;
      end
      return r[31:0];
   endfunction

endpackage

/* hw/rtl/pid_controller_position_delta.sv */
// path: req transaction to rsp_valid through the input register, then the result register
// throughput: one transaction per cycle unless an unaccepted result stalls the output; the
//    three gain multiplies and the clamps sit in the combinational logic between the input
//    register and the state/result registers; reset: synchronous; mode positional, gains
//    zero, limits at maximum, band 65536, error history, integral and output cleared
// ----------------------------------------------------------------------------
// pid controller, positional and incremental
// error history, gain products, saturation and output clamp
// ----------------------------------------------------------------------------
`include "pid_controller_position_delta_defines.svh"

module pid_controller_position_delta
   import pidpd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_setpoint,
   input  logic signed [15:0] req_measured,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [1:0]         mode_ff;
   logic signed [23:0] kp_ff;
   logic signed [23:0] ki_ff;
   logic signed [23:0] kd_ff;
   logic [30:0]        olim_ff;
   logic [30:0]        ilim_ff;
   logic [16:0]        band_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_POSITIONAL;
         kp_ff   <= '0;
         ki_ff   <= '0;
         kd_ff   <= '0;
         olim_ff <= LIMIT_RESET;
         ilim_ff <= LIMIT_RESET;
         band_ff <= BAND_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_LOOP_MODE:      mode_ff <= csr_wdata[1:0];
            REG_KP_GAIN:        kp_ff   <= csr_wdata[23:0];
            REG_KI_GAIN:        ki_ff   <= csr_wdata[23:0];
            REG_KD_GAIN:        kd_ff   <= csr_wdata[23:0];
            REG_OUTPUT_LIMIT:   olim_ff <= csr_wdata[30:0];
            REG_INTEGRAL_LIMIT: ilim_ff <= csr_wdata[30:0];
            REG_INTEGRAL_BAND:  band_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // handshake
   logic a_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic accept;

   assign advance   = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // input stage with error history shift
   logic signed [16:0] err_in;
   logic signed [16:0] hist0_ff;
   logic signed [16:0] hist1_ff;
   logic signed [16:0] a_e0_ff;
   logic signed [16:0] a_e1_ff;
   logic signed [16:0] a_e2_ff;

   assign err_in = {req_setpoint[15], req_setpoint} - {req_measured[15], req_measured};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         hist0_ff   <= '0;
         hist1_ff   <= '0;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
            hist0_ff   <= err_in;
            hist1_ff   <= hist0_ff;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_e0_ff <= err_in;
         a_e1_ff <= hist0_ff;
         a_e2_ff <= hist1_ff;
      end
   end

   // term computation
   logic               is_pos;
   logic               is_inc;
   logic signed [17:0] de1;
   logic signed [18:0] dd2;
   logic [16:0]        mag;
   logic               in_band;
   logic signed [17:0] p_op;
   logic signed [18:0] d_op;
   logic signed [41:0] p_prod;
   logic signed [40:0] i_prod;
   logic signed [42:0] d_prod;
   logic signed [31:0] p_term;
   logic signed [31:0] i_term;
   logic signed [31:0] d_term;
   logic signed [33:0] integ_sum;
   logic signed [31:0] integ_pos;
   logic signed [33:0] out_sum;
   logic signed [31:0] out_clamped;
   logic signed [31:0] integ_ff;
   logic signed [31:0] integ_in;
   logic signed [31:0] held_ff;
   logic signed [31:0] held_in;

   assign is_pos  = (mode_ff == MODE_POSITIONAL);
   assign is_inc  = (mode_ff == MODE_INCREMENTAL);
   assign de1     = 18'(a_e0_ff) - 18'(a_e1_ff);
   assign dd2     = 19'(a_e0_ff) - (19'(a_e1_ff) <<< 1) + 19'(a_e2_ff);
   assign mag     = a_e0_ff[16] ? 17'(-a_e0_ff) : 17'(a_e0_ff);
   assign in_band = mag < band_ff;
   assign p_op    = is_inc ? de1 : 18'(a_e0_ff);
   assign d_op    = is_inc ? dd2 : 19'(de1);
   assign p_prod  = 42'(kp_ff) * 42'(p_op);
   assign i_prod  = 41'(ki_ff) * 41'(a_e0_ff);
   assign d_prod  = 43'(kd_ff) * 43'(d_op);
   assign p_term  = sat_term(43'(p_prod));
   assign i_term  = in_band ? sat_term(43'(i_prod)) : 32'sd0;
   assign d_term  = sat_term(d_prod);

   assign integ_sum = 34'(integ_ff) + 34'(i_term);
   assign integ_pos = clamp_lim(integ_sum, ilim_ff);

   always_comb begin
      if (is_inc) begin
         out_sum = 34'(held_ff) + 34'(p_term) + 34'(i_term) + 34'(d_term);
      end else begin
         out_sum = 34'(p_term) + 34'(integ_pos) + 34'(d_term);
      end
   end

   assign out_clamped = clamp_lim(out_sum, olim_ff);

   always_comb begin
      case (loop_mode_type'(mode_ff))
         MODE_POSITIONAL: begin
            integ_in = integ_pos;
            held_in  = out_clamped;
         end
         MODE_INCREMENTAL: begin
            integ_in = i_term;
            held_in  = out_clamped;
         end
         default: begin
            integ_in = integ_ff;
            held_in  = held_ff;
         end
      endcase
   end

   // state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         held_ff      <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            integ_ff     <= integ_in;
            held_ff      <= held_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_drive = held_ff;

   // checks
   `PIDPD_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ready, !advance, "pending transaction overwritten")
   `PIDPD_ASSERT_NEXT(a_out_clamp, clock, reset, advance && (is_pos || is_inc), (34'(held_ff) <= signed'({3'b000, $past(olim_ff)})) && (34'(held_ff) >= -signed'({3'b000, $past(olim_ff)})), "drive outside output limit")
   `PIDPD_ASSERT_NEXT(a_integ_clamp, clock, reset, advance && is_pos, (34'(integ_ff) <= signed'({3'b000, $past(ilim_ff)})) && (34'(integ_ff) >= -signed'({3'b000, $past(ilim_ff)})), "integral outside limit")
   `PIDPD_ASSERT_NEXT(a_hold_keeps, clock, reset, advance && !is_pos && !is_inc, (held_ff == $past(held_ff)) && (integ_ff == $past(integ_ff)), "hold mode changed state")

endmodule

/* tb/sv/pid_drive_sb_pkg.sv */
// ----------------------------------------------------------------------------
// pid controller drive scoreboard
// predicts the drive of every accepted transaction from its own copy of the
// error history, integral, held output and registers, and checks each result
// in order against the oldest prediction
// ----------------------------------------------------------------------------
package pid_drive_sb_pkg;
   import pidpd_pkg::*;

   localparam longint TERM_SAT = 64'sd2147483647;

   class drive_scoreboard;
      logic [1:0] mode;
      longint kp;
      longint ki;
      longint kd;
      longint out_lim;
      longint int_lim;
      longint band;
      longint err0;
      longint err1;
      longint err2;
      longint integ;
      longint held;
      logic signed [31:0] expected_drive[$];
      int mismatches;
      int checked;

      function new();
         mode = MODE_POSITIONAL;
         kp = 0;
         ki = 0;
         kd = 0;
         out_lim = TERM_SAT;
         int_lim = TERM_SAT;
         band = 65536;
         err0 = 0;
         err1 = 0;
         err2 = 0;
         integ = 0;
         held = 0;
         mismatches = 0;
         checked = 0;
      endfunction

      function longint limit_to(longint v, longint lim);
         if (v > lim) begin
            return lim;
         end else if (v < -lim) begin
            return -lim;
         end
         return v;
      endfunction

      function void set_reg(logic [2:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_LOOP_MODE:      mode = val[1:0];
            REG_KP_GAIN:        kp = longint'(signed'(val[23:0]));
            REG_KI_GAIN:        ki = longint'(signed'(val[23:0]));
            REG_KD_GAIN:        kd = longint'(signed'(val[23:0]));
            REG_OUTPUT_LIMIT:   out_lim = longint'(val[30:0]);
            REG_INTEGRAL_LIMIT: int_lim = longint'(val[30:0]);
            REG_INTEGRAL_BAND:  band = longint'(val[16:0]);
            default: ;
         endcase
      endfunction

      function void accept_sample(logic signed [15:0] sp, logic signed [15:0] ms);
         longint mag;
         longint p;
         longint i_inc;
         longint d;
         err2 = err1;
         err1 = err0;
         err0 = longint'(sp) - longint'(ms);
         mag = (err0 < 0) ? -err0 : err0;
         if (mode == MODE_POSITIONAL) begin
            p = limit_to(kp * err0, TERM_SAT);
            if (mag < band) begin
               integ = integ + limit_to(ki * err0, TERM_SAT);
            end
            integ = limit_to(integ, int_lim);
            d = limit_to(kd * (err0 - err1), TERM_SAT);
            held = limit_to(p + integ + d, out_lim);
         end else if (mode == MODE_INCREMENTAL) begin
            p = limit_to(kp * (err0 - err1), TERM_SAT);
            i_inc = (mag < band) ? limit_to(ki * err0, TERM_SAT) : 0;
            integ = i_inc;
            d = limit_to(kd * (err0 - 2 * err1 + err2), TERM_SAT);
            held = limit_to(held + p + i_inc + d, out_lim);
         end
         expected_drive.push_back(held[31:0]);
      endfunction

      function void check_drive(logic signed [31:0] actual);
         logic signed [31:0] want;
         if (expected_drive.size() == 0) begin
            $error("drive: unexpected result, expected none actual %0d", actual);
            mismatches++;
         end else begin
            want = expected_drive.pop_front();
            checked++;
            if (actual !== want) begin
               $error("drive mismatch: expected %0d actual %0d", want, actual);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_drive.size();
      endfunction
   endclass

endpackage

/* tb/sv/tb_pid_controller_position_delta.sv */
// ----------------------------------------------------------------------------
// pid controller testbench
// directed extremes and special cases, then random samples and register
// settings under three idle patterns and a long output stall; every drive is
// checked against the scoreboard prediction
// ----------------------------------------------------------------------------
module tb_pid_controller_position_delta;
   import pidpd_pkg::*;
   import pid_drive_sb_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD = 300;
   localparam int ONE = 65536;
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam logic [30:0] LIMIT_MAX = 31'h7FFF_FFFF;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [15:0] req_setpoint;
   logic signed [15:0] req_measured;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [31:0] rsp_drive;
   logic csr_we;
   logic [2:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   drive_scoreboard sb = new();
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int rx_hold_len = 0;
   int idle_cycles = 0;
   int settings_used = 0;
   int items_sent = 0;

   pid_controller_position_delta dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_setpoint (req_setpoint),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold_len > 0) begin
            rsp_ready <= 1'b0;
            rx_hold_len--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_drive(rsp_drive);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_csr(input logic [2:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [1:0] mode, input logic [23:0] kp,
                                 input logic [23:0] ki, input logic [23:0] kd,
                                 input logic [30:0] olim, input logic [30:0] ilim,
                                 input logic [16:0] band);
      write_csr(REG_LOOP_MODE, {29'd0, mode});
      write_csr(REG_KP_GAIN, {7'd0, kp});
      write_csr(REG_KI_GAIN, {7'd0, ki});
      write_csr(REG_KD_GAIN, {7'd0, kd});
      write_csr(REG_OUTPUT_LIMIT, olim);
      write_csr(REG_INTEGRAL_LIMIT, ilim);
      write_csr(REG_INTEGRAL_BAND, {14'd0, band});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic send_item(input logic signed [15:0] sp, input logic signed [15:0] ms);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_setpoint <= sp;
      req_measured <= ms;
      do @(posedge clock); while (!req_ready);
      sb.accept_sample(sp, ms);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   function automatic logic [23:0] pick_gain();
      case ($urandom_range(5))
         0: return 24'h7F_FFFF;
         1: return 24'h80_0000;
         2: return 24'd0;
         3, 4: return 24'($urandom_range(2 * ONE)) - 24'(ONE);
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [30:0] pick_limit();
      case ($urandom_range(4))
         0: return LIMIT_MAX;
         1: return 31'd0;
         2, 3: return 31'($urandom_range(1000)) << 16;
         default: return 31'($urandom);
      endcase
   endfunction

   function automatic logic [16:0] pick_band();
      case ($urandom_range(5))
         0: return 17'd0;
         1: return BAND_RESET;
         2: return 17'h1_FFFF;
         3, 4: return 17'($urandom_range(400));
         default: return 17'($urandom);
      endcase
   endfunction

   function automatic logic [1:0] pick_mode();
      int r;
      r = $urandom_range(9);
      if (r < 4) begin
         return MODE_POSITIONAL;
      end else if (r < 8) begin
         return MODE_INCREMENTAL;
      end else if (r == 8) begin
         return MODE_HOLD;
      end
      return MODE_RESERVED;
   endfunction

   task automatic send_random(input int count);
      logic signed [15:0] sp;
      logic signed [15:0] ms;
      int kind;
      repeat (count) begin
         kind = $urandom_range(9);
         sp = 16'($urandom);
         if (kind < 5) begin
            ms = sp + 16'(int'($urandom_range(300)) - 150);
         end else if (kind < 8) begin
            ms = 16'($urandom);
         end else if (kind == 8) begin
            sp = 16'sh7FFF;
            ms = ($urandom_range(1) != 0) ? 16'sh8000 : 16'sh7FFF;
         end else begin
            sp = 16'sh8000;
            ms = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
         end
         send_item(sp, ms);
      end
   endtask

   task automatic random_segment(input int count);
      drain();
      apply_settings(pick_mode(), pick_gain(), pick_gain(), pick_gain(),
                     pick_limit(), pick_limit(), pick_band());
      send_random(count);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_setpoint = '0;
      req_measured = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      tx_idle_pct = 16;
      rx_idle_pct = 63;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults after reset
      send_item(16'sd1000, -16'sd1000);
      send_item(16'sh7FFF, 16'sh8000);
      drain();

      // unit, half and quarter gains, full error range
      apply_settings(MODE_POSITIONAL, 24'(ONE), 24'(ONE / 2), 24'(ONE / 4),
                     LIMIT_MAX, LIMIT_MAX, BAND_RESET);
      send_item(16'sd0, 16'sd0);
      send_item(16'sd5, -16'sd3);
      send_item(16'sh7FFF, 16'sh8000);
      send_item(16'sh8000, 16'sh7FFF);
      send_item(16'sd100, 16'sd100);
      drain();

      // gain extremes saturate every term
      apply_settings(MODE_POSITIONAL, 24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF,
                     LIMIT_MAX, LIMIT_MAX, 17'h1_FFFF);
      send_item(16'sh7FFF, 16'sh8000);
      send_item(16'sh8000, 16'sh7FFF);
      send_item(16'sd0, 16'sd0);
      drain();

      // integral band and clamp, clamp still applied outside the band
      apply_settings(MODE_POSITIONAL, 24'd0, 24'(ONE), 24'd0,
                     LIMIT_MAX, 31'(5 * ONE), 17'd10);
      send_item(16'sd3, 16'sd0);
      send_item(16'sd3, 16'sd0);
      send_item(16'sd3, 16'sd0);
      send_item(16'sd20, 16'sd0);
      send_item(16'sd10, 16'sd0);
      drain();
      write_csr(REG_INTEGRAL_LIMIT, 31'(2 * ONE));
      write_csr(REG_UNUSED, 31'h5A5A_5A5A);
      csr_we <= 1'b0;
      send_item(16'sd50, 16'sd0);
      drain();

      // incremental with output clamp
      apply_settings(MODE_INCREMENTAL, 24'(ONE), 24'(ONE / 2), 24'(ONE),
                     31'(100 * ONE), LIMIT_MAX, BAND_RESET);
      send_item(16'sd10, 16'sd0);
      send_item(16'sd30, 16'sd0);
      send_item(-16'sd5, 16'sd0);
      send_item(16'sh7FFF, 16'sh8000);
      drain();

      // hold keeps the stored output even above a tighter limit
      apply_settings(MODE_HOLD, 24'(ONE), 24'(ONE), 24'(ONE), 31'(ONE), LIMIT_MAX, BAND_RESET);
      send_item(16'sd400, -16'sd7);
      send_item(-16'sd12, 16'sd9);
      drain();
      apply_settings(MODE_RESERVED, 24'(ONE), 24'(ONE), 24'(ONE), 31'(ONE), LIMIT_MAX,
                     BAND_RESET);
      send_item(16'sd77, 16'sd1);
      drain();

      // positional picks up the integral left by the incremental step
      apply_settings(MODE_POSITIONAL, 24'(ONE), 24'(ONE), 24'(ONE), LIMIT_MAX, LIMIT_MAX,
                     17'd0);
      send_item(16'sd2, 16'sd0);
      drain();
      apply_settings(MODE_POSITIONAL, 24'(ONE), 24'(ONE), 24'(ONE), 31'd0, 31'd0, 17'd0);
      send_item(16'sd9, -16'sd9);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0) begin
            tx_idle_pct = 16;
            rx_idle_pct = 63;
         end else if (phase == 1) begin
            tx_idle_pct = 63;
            rx_idle_pct = 16;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         repeat (3) random_segment(45);
      end

      // long output stall while transactions keep coming
      drain();
      rx_hold_len = LONG_HOLD;
      send_random(40);

      drain();
      repeat (6) @(negedge clock);
      $display("summary: %0d transactions, %0d register settings, %0d drive results checked",
               items_sent, settings_used, sb.checked);
      $display("summary: all loop modes, gain and limit extremes, band edges, long stall");
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
